// ===== rtl/mesh_vertex_dedup_indexer_assert.svh =====
// Assertion macros used by the port-level checker.
`ifndef MESH_VERTEX_DEDUP_INDEXER_ASSERT_SVH
`define MESH_VERTEX_DEDUP_INDEXER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define MVD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MVD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/mvd_pkg.sv =====
// Package with types, constants and state codes of the vertex indexer.
package mvd_pkg;
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam logic [10:0] LIMIT_RST = 11'd1024;
  localparam logic [15:0] TOL_RST = 16'd7;
  localparam int NRM_W = 18;

  localparam logic [1:0] ST_MATCH = 2'd0;
  localparam logic [1:0] ST_APPEND = 2'd1;
  localparam logic [1:0] ST_DROP = 2'd2;

  localparam logic CFG_LIMIT = 1'b0;
  localparam logic CFG_TOL = 1'b1;

  typedef struct packed {
    logic               start_mesh;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] raw_nrm_x;
    logic signed [31:0] raw_nrm_y;
    logic signed [31:0] raw_nrm_z;
  } in_req_t;

  typedef struct packed {
    logic [9:0]  vertex_index;
    logic [1:0]  status;
    logic [10:0] vertex_count;
  } out_res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SUM, S_SQRT, S_DIVX, S_DIVY, S_DIVZ, S_SCAN, S_DONE
  } state_t;

  typedef struct packed {
    logic               start;
    logic [63:0]        num;
    logic [31:0]        den;
  } div_req_t;
endpackage

// ===== rtl/mvd_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module mvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/mvd_divider.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit numerator.
module mvd_divider
  import mvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        done,
  output logic [31:0] quot
);
  logic [63:0] num_r, num_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic [63:0] q_r, q_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] trial;
  logic [32:0] rem_step;
  logic [63:0] q_step;

  always_comb begin
    trial = {rem_r[31:0], num_r[63]};
    if (trial >= {1'b0, den_r}) begin
      rem_step = trial - {1'b0, den_r};
      q_step = {q_r[62:0], 1'b1};
    end else begin
      rem_step = trial;
      q_step = {q_r[62:0], 1'b0};
    end
    // The last step finishes even when a new request loads in the same cycle.
    done = busy_r && (cnt_r == 7'd1);
    num_nxt = num_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      num_nxt = {num_r[62:0], 1'b0};
      rem_nxt = rem_step;
      q_nxt = q_step;
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
    if (req.start) begin
      num_nxt = req.num;
      rem_nxt = '0;
      q_nxt = '0;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end
  end

  // Quotient fits in 17 bits since the magnitude bounds every component.
  assign quot = q_step[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    if (req.start) den_r <= req.den;
  end
endmodule

// ===== rtl/mesh_vertex_dedup_indexer.sv =====
// Top level of the mesh vertex welding indexer.
// A request steps through the square, sum, square-root, x, y and z divide, scan and done states.
// A zero normal skips the divides; a hit at entry k ends the search without reading later entries.
// Throughput: one request at a time; busy is high from acceptance to the result strobe.
// The magnitude comes from a bit-pair square root, the components from a serial divider,
// and the search reads one stored entry a cycle; synchronous active-low reset empties the table.
module mesh_vertex_dedup_indexer
  import mvd_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_req,
  output logic        out_valid,
  output out_res_t    out_res,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int EW = 3 * 32 + 3 * NRM_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_t state_r, state_nxt;
  logic [10:0] limit_r;
  logic [15:0] tol_r;
  logic [CW-1:0] count_r, count_nxt;
  in_req_t req_r;
  logic [63:0] sqx_r, sqy_r, sqz_r;
  logic [63:0] rem_r, rem_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic signed [NRM_W-1:0] nx_r, ny_r, nz_r;
  logic [CW-1:0] j_r, j_nxt;
  logic rd_pend_r, rd_pend_nxt;
  logic found_r, found_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic out_v_r, out_v_nxt;
  out_res_t res_r, res_nxt;
  logic we;
  logic [EW-1:0] wdata, rdata;
  logic [AW-1:0] raddr;
  div_req_t dreq;
  logic ddone;
  logic [31:0] dquot;
  logic signed [NRM_W-1:0] qs;
  logic [CW-1:0] lim_eff;

  mvd_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(count_r[AW-1:0]), .wdata(wdata),
    .raddr(raddr), .rdata(rdata));

  mvd_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dquot));

  function automatic logic [31:0] absv(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  function automatic logic nearv(input logic signed [31:0] a, input logic signed [31:0] b,
                                 input logic [15:0] t);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d[32]) d = -d;
    return d <= $signed({17'd0, t});
  endfunction

  logic signed [31:0] e_px, e_py, e_pz, e_nx, e_ny, e_nz;
  logic hit;
  assign e_px = rdata[EW-1 -: 32];
  assign e_py = rdata[EW-33 -: 32];
  assign e_pz = rdata[EW-65 -: 32];
  assign e_nx = 32'(signed'(rdata[3*NRM_W-1 -: NRM_W]));
  assign e_ny = 32'(signed'(rdata[2*NRM_W-1 -: NRM_W]));
  assign e_nz = 32'(signed'(rdata[NRM_W-1:0]));
  assign hit = nearv(req_r.pos_x, e_px, tol_r) && nearv(req_r.pos_y, e_py, tol_r) &&
               nearv(req_r.pos_z, e_pz, tol_r) && nearv(32'(nx_r), e_nx, tol_r) &&
               nearv(32'(ny_r), e_ny, tol_r) && nearv(32'(nz_r), e_nz, tol_r);
  assign wdata = {req_r.pos_x, req_r.pos_y, req_r.pos_z, nx_r, ny_r, nz_r};
  assign raddr = j_r[AW-1:0];
  assign lim_eff = (int'(limit_r) < TABLE_DEPTH) ? CW'(limit_r) : DEPTH_C;
  assign busy = (state_r != S_IDLE);
  assign out_valid = out_v_r;
  assign out_res = res_r;

  function automatic logic [31:0] comp(input logic signed [31:0] c);
    return absv(c);
  endfunction

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rem_nxt = rem_r;
    root_nxt = root_r;
    bit_nxt = bit_r;
    j_nxt = j_r;
    rd_pend_nxt = 1'b0;
    found_nxt = found_r;
    idx_nxt = idx_r;
    out_v_nxt = 1'b0;
    res_nxt = res_r;
    we = 1'b0;
    dreq = '0;
    qs = NRM_W'(signed'(dquot[NRM_W-1:0]));
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SQ;
          if (in_req.start_mesh) count_nxt = '0;
        end
      end
      S_SQ: state_nxt = S_SUM;
      S_SUM: begin
        state_nxt = S_SQRT;
        rem_nxt = sqx_r + sqy_r + sqz_r;
        root_nxt = '0;
        bit_nxt = 64'd1 << 62;
      end
      S_SQRT: begin
        if (bit_r == '0) begin
          if (root_r == '0) begin
            state_nxt = S_SCAN;
            j_nxt = '0;
          end else begin
            state_nxt = S_DIVX;
            dreq.start = 1'b1;
            dreq.num = {16'd0, comp(req_r.raw_nrm_x), 16'd0} + {1'b0, root_r[63:1]};
            dreq.den = root_r[31:0];
          end
        end else begin
          if (rem_r >= root_r + bit_r) begin
            rem_nxt = rem_r - (root_r + bit_r);
            root_nxt = (root_r >> 1) + bit_r;
          end else begin
            root_nxt = root_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
      end
      S_DIVX: if (ddone) begin
        state_nxt = S_DIVY;
        dreq.start = 1'b1;
        dreq.num = {16'd0, comp(req_r.raw_nrm_y), 16'd0} + {1'b0, root_r[63:1]};
        dreq.den = root_r[31:0];
      end
      S_DIVY: if (ddone) begin
        state_nxt = S_DIVZ;
        dreq.start = 1'b1;
        dreq.num = {16'd0, comp(req_r.raw_nrm_z), 16'd0} + {1'b0, root_r[63:1]};
        dreq.den = root_r[31:0];
      end
      S_DIVZ: if (ddone) begin
        state_nxt = S_SCAN;
        j_nxt = '0;
      end
      S_SCAN: begin
        // One entry is read per cycle; its data is compared the cycle after.
        if (rd_pend_r && hit) begin
          state_nxt = S_DONE;
          found_nxt = 1'b1;
          idx_nxt = AW'(j_r - CW'(1));
        end else if (j_r >= count_r || j_r == DEPTH_C) begin
          state_nxt = S_DONE;
          found_nxt = 1'b0;
        end else begin
          rd_pend_nxt = 1'b1;
          j_nxt = j_r + CW'(1);
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
        out_v_nxt = 1'b1;
        if (found_r) begin
          res_nxt.vertex_index = 10'(idx_r);
          res_nxt.status = ST_MATCH;
        end else if (count_r < lim_eff) begin
          we = 1'b1;
          res_nxt.vertex_index = 10'(count_r);
          res_nxt.status = ST_APPEND;
          count_nxt = count_r + CW'(1);
        end else begin
          res_nxt.vertex_index = '0;
          res_nxt.status = ST_DROP;
        end
        res_nxt.vertex_count = 11'(count_nxt);
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_SCAN && state_nxt == S_SCAN && j_r == '0) found_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      limit_r <= LIMIT_RST;
      tol_r <= TOL_RST;
      out_v_r <= 1'b0;
      rd_pend_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_v_r <= out_v_nxt;
      rd_pend_r <= rd_pend_nxt;
      found_r <= found_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LIMIT: limit_r <= cfg_wdata[10:0];
          CFG_TOL: tol_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    if (state_r == S_IDLE && start) req_r <= in_req;
    if (state_r == S_SQ) begin
      sqx_r <= 64'(req_r.raw_nrm_x * req_r.raw_nrm_x);
      sqy_r <= 64'(req_r.raw_nrm_y * req_r.raw_nrm_y);
      sqz_r <= 64'(req_r.raw_nrm_z * req_r.raw_nrm_z);
    end
    if (state_r == S_SQRT && bit_r == '0) begin
      nx_r <= '0;
      ny_r <= '0;
      nz_r <= '0;
    end
    if (ddone) begin
      if (state_r == S_DIVX) nx_r <= req_r.raw_nrm_x[31] ? -qs : qs;
      if (state_r == S_DIVY) ny_r <= req_r.raw_nrm_y[31] ? -qs : qs;
      if (state_r == S_DIVZ) nz_r <= req_r.raw_nrm_z[31] ? -qs : qs;
    end
    rem_r <= rem_nxt;
    root_r <= root_nxt;
    bit_r <= bit_nxt;
    j_r <= j_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end
endmodule

// ===== rtl/mvd_checker.sv =====
// Port-level checker for the vertex indexer, bound to the top level.
`include "mesh_vertex_dedup_indexer_assert.svh"
module mvd_checker
  import mvd_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input out_res_t out_res
);
  `MVD_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `MVD_ASSERT_NXT(a_strobe_pulse, clk, rst_n, out_valid, !out_valid)
  `MVD_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, out_res.status != 2'd3)
  `MVD_ASSERT_IMP(a_drop_index, clk, rst_n, out_valid && out_res.status == ST_DROP, out_res.vertex_index == '0)
endmodule

bind mesh_vertex_dedup_indexer mvd_checker u_mvd_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_res(out_res));

// ===== verif/tb.sv =====
// Self-checking testbench for the mesh vertex welding indexer.
module tb;
  import mvd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class weld_scoreboard;
    logic signed [31:0] pos_tab[3][TABLE_DEPTH_DEF];
    logic signed [31:0] nrm_tab[3][TABLE_DEPTH_DEF];
    int unsigned count;
    int unsigned limit;
    int unsigned tol;
    out_res_t pending[$];
    int errors;
    int checked;
    int n_match;
    int n_append;
    int n_drop;

    function new();
      count = 0;
      limit = LIMIT_RST;
      tol = TOL_RST;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] d);
      if (idx == CFG_LIMIT) limit = d[10:0];
      else tol = d;
    endfunction

    function longint unsigned root64(longint unsigned s);
      longint unsigned root;
      longint unsigned b;
      root = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
        if (s >= root + b) begin
          s = s - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      return root;
    endfunction

    function logic signed [31:0] to_unit(longint c, longint unsigned mag);
      longint unsigned a;
      longint unsigned q;
      a = (c < 0) ? -c : c;
      q = (a * 65536 + mag / 2) / mag;
      return (c < 0) ? -$signed(q[31:0]) : $signed(q[31:0]);
    endfunction

    function bit near(longint a, longint b);
      longint d;
      d = a - b;
      if (d < 0) d = -d;
      return d <= longint'(tol);
    endfunction

    function void note(in_req_t r);
      longint raw[3];
      longint pos[3];
      logic signed [31:0] un[3];
      longint unsigned sum;
      longint unsigned mag;
      int unsigned cap;
      bit hit;
      out_res_t res;
      raw[0] = r.raw_nrm_x; raw[1] = r.raw_nrm_y; raw[2] = r.raw_nrm_z;
      pos[0] = r.pos_x; pos[1] = r.pos_y; pos[2] = r.pos_z;
      if (r.start_mesh) count = 0;
      sum = 0;
      for (int k = 0; k < 3; k++) sum += longint'(raw[k] * raw[k]);
      mag = root64(sum);
      for (int k = 0; k < 3; k++) un[k] = (mag == 0) ? 0 : to_unit(raw[k], mag);
      hit = 0;
      res = '0;
      res.status = ST_DROP;
      for (int j = 0; j < count && !hit; j++) begin
        hit = 1;
        for (int k = 0; k < 3; k++)
          if (!near(pos[k], pos_tab[k][j]) || !near(un[k], nrm_tab[k][j])) hit = 0;
        if (hit) begin
          res.vertex_index = 10'(j);
          res.status = ST_MATCH;
        end
      end
      if (!hit) begin
        cap = (limit < TABLE_DEPTH_DEF) ? limit : TABLE_DEPTH_DEF;
        if (count < cap) begin
          for (int k = 0; k < 3; k++) begin
            pos_tab[k][count] = 32'(pos[k]);
            nrm_tab[k][count] = un[k];
          end
          res.vertex_index = 10'(count);
          res.status = ST_APPEND;
          count++;
        end
      end
      res.vertex_count = 11'(count);
      pending.push_back(res);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check(out_res_t got);
      out_res_t want;
      if (pending.size() == 0) begin
        $display("mismatch at %0t: result with no request outstanding", $time);
        errors++;
      end else begin
        want = pending.pop_front();
        checked++;
        case (want.status)
          ST_MATCH: n_match++;
          ST_APPEND: n_append++;
          default: n_drop++;
        endcase
        if (got.vertex_index !== want.vertex_index)
          report("vertex_index", got.vertex_index, want.vertex_index);
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.vertex_count !== want.vertex_count)
          report("vertex_count", got.vertex_count, want.vertex_count);
      end
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  in_req_t in_req = '0;
  logic out_valid;
  out_res_t out_res;
  logic cfg_we = 0;
  logic cfg_index = CFG_LIMIT;
  logic [15:0] cfg_wdata = '0;

  weld_scoreboard sb = new();
  in_req_t recent[$];
  int unsigned cur_tol = TOL_RST;

  mesh_vertex_dedup_indexer dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_res);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task send(in_req_t r);
    start = 1;
    in_req = r;
    do @(posedge clk); while (busy);
    sb.note(r);
    if (recent.size() > 30) void'(recent.pop_front());
    recent.push_back(r);
    @(negedge clk);
  endtask

  task pause();
    int n;
    n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(20, 150);
    if (n > 0) begin
      start = 0;
      repeat (n) @(negedge clk);
    end
  endtask

  task drain();
    start = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task write_reg(logic idx, logic [15:0] d);
    drain();
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = d;
    @(negedge clk);
    cfg_we = 0;
    sb.set_reg(idx, d);
    if (idx == CFG_TOL) cur_tol = d;
  endtask

  function in_req_t vtx(bit s, int px, int py, int pz, int nx, int ny, int nz);
    in_req_t r;
    r.start_mesh = s;
    r.pos_x = px; r.pos_y = py; r.pos_z = pz;
    r.raw_nrm_x = nx; r.raw_nrm_y = ny; r.raw_nrm_z = nz;
    return r;
  endfunction

  function logic signed [31:0] any_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 400)) - 200;
      2: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  // Mostly re-sends a recent vertex, nudged around the tolerance, at times with its normal scaled by three.
  function in_req_t next_vertex(bit s);
    in_req_t r;
    int d;
    if (recent.size() != 0 && $urandom_range(0, 9) < 6) begin
      r = recent[$urandom_range(0, recent.size() - 1)];
      d = $signed($urandom_range(0, 2 * cur_tol + 2)) - $signed(cur_tol + 1);
      case ($urandom_range(0, 2))
        0: r.pos_x = r.pos_x + d;
        1: r.pos_y = r.pos_y + d;
        default: r.pos_z = r.pos_z + d;
      endcase
      if ($urandom_range(0, 1) && r.raw_nrm_x > -1000 && r.raw_nrm_x < 1000 &&
          r.raw_nrm_y > -1000 && r.raw_nrm_y < 1000 &&
          r.raw_nrm_z > -1000 && r.raw_nrm_z < 1000) begin
        r.raw_nrm_x *= 3; r.raw_nrm_y *= 3; r.raw_nrm_z *= 3;
      end
    end else begin
      r = vtx(0, any_word(), any_word(), any_word(), any_word(), any_word(), any_word());
    end
    r.start_mesh = s;
    return r;
  endfunction

  initial begin
    #50ms;
    $display("timeout at %0t", $time);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int lims[8];
    int tols[5];
    int left;
    int wait_cycles;
    lims = '{1, 3, 16, 40, 2047, 1024, 0, 1025};
    tols = '{0, 7, 300, 65535, 2};
    repeat (9) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed part, first with reset settings, then with written limit and tolerance.
    send(vtx(1, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0, 0));
    send(vtx(0, 32'sh7fff_ffff, 32'sh7fff_fff8, 32'sh7fff_ffff, 0, 0, 0));
    send(vtx(0, 32'sh7fff_ffff, 32'sh7fff_fff7, 32'sh7fff_ffff, 0, 0, 0));
    send(vtx(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send(vtx(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, -1, -1, -1));
    send(vtx(0, 0, 0, 0, 32'sh7fff_ffff, 0, 0));
    send(vtx(0, 0, 0, 0, 1, 0, 0));
    send(vtx(0, 0, 0, 0, 0, -5, 0));
    send(vtx(0, 0, 0, 0, 3, 4, 0));
    send(vtx(0, 0, 0, 0, 300, 400, 1));
    send(vtx(0, -1, -1, -1, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000));
    send(vtx(1, 5, 5, 5, 0, 0, 1));
    write_reg(CFG_TOL, 16'hffff);
    write_reg(CFG_LIMIT, 16'd2);
    send(vtx(1, 0, 0, 0, 0, 0, 1));
    send(vtx(0, 65535, -65535, 65535, 0, 0, 1));
    send(vtx(0, 65536, 0, 0, 0, 0, 1));
    send(vtx(0, 200000, 0, 0, 0, 0, 1));
    send(vtx(0, 0, 0, 0, 0, 0, -1));
    write_reg(CFG_LIMIT, 16'd0);
    write_reg(CFG_TOL, 16'd0);
    send(vtx(0, 0, 0, 0, 0, 0, 1));
    send(vtx(0, 1, 0, 0, 0, 0, 1));
    send(vtx(1, 1, 0, 0, 0, 0, 1));
    write_reg(CFG_LIMIT, 16'd2047);
    send(vtx(0, 1, 0, 0, 0, 0, 1));
    send(vtx(0, 1, 0, 0, 0, 0, 7));

    // Random phases, each with its own settings and a few meshes.
    left = 450;
    while (left > 0) begin
      write_reg(CFG_LIMIT, 16'(lims[$urandom_range(0, 7)]));
      write_reg(CFG_TOL, ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'(tols[$urandom_range(0, 4)]));
      for (int i = 0; i < 75 && left > 0; i++) begin
        send(next_vertex(i == 0 || $urandom_range(0, 24) == 0));
        left--;
        if ($urandom_range(0, 39) == 0) drain();
        else pause();
      end
    end

    start = 0;
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 5000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (1400) @(negedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("checked %0d results: %0d matched, %0d appended, %0d dropped",
             sb.checked, sb.n_match, sb.n_append, sb.n_drop);
    $display("limits from 0 to 2047 and tolerances from 0 to 65535 were exercised");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== mesh_vertex_dedup_indexer.f =====
+incdir+rtl
rtl/mvd_pkg.sv
rtl/mvd_ram.sv
rtl/mvd_divider.sv
rtl/mesh_vertex_dedup_indexer.sv
rtl/mvd_checker.sv
verif/tb.sv
